/* rtl/core/q4kbd_pkg.sv */
// Shared types, constants and conversion functions of the Q4_K block dequantizer.
// Used by every module of the block; depends on nothing.
package q4kbd_pkg;

  localparam int unsigned ROW_W = 20;
  localparam int unsigned OFS_W = 7;
  localparam logic [ROW_W-1:0] ROW_LENGTH_RESET = 20'd256;
  localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET_BIT = 32'h0040_0000;

  typedef struct packed {
    logic [31:0] block_word;
    logic        start_of_row;
  } in_t;

  typedef struct packed {
    logic [31:0]      value;
    logic [ROW_W-1:0] element_index;
    logic             end_of_row;
    logic             last_of_item;
  } out_t;

  typedef struct packed {
    logic [31:0]      word;
    logic [31:0]      d;
    logic [31:0]      dmin;
    logic [95:0]      codes;
    logic [ROW_W-1:0] index;
    logic [3:0]       count;
    logic             eor;
    logic [2:0]       sb;
    logic [OFS_W-1:0] ofs;
  } job_t;

  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  fr;
    logic [3:0]  k;
    logic [10:0] t;
    logic [7:0]  e;
    logic [31:0] r;
    ex = h[14:10];
    fr = h[9:0];
    k = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (fr[i]) k = 4'(10 - i);
    end
    t = {1'b0, fr} << k;
    e = 8'd113 - 8'(k);
    if (ex == 5'd0) begin
      r = (fr == 10'd0) ? {h[15], 31'd0} : {h[15], e, t[9:0], 13'd0};
    end else if (ex == 5'd31) begin
      r = {h[15], 8'hFF, fr, 13'd0};
    end else begin
      r = {h[15], 8'(ex) + 8'd112, fr, 13'd0};
    end
    return r;
  endfunction

  // n/63 is the six bits of n repeated forever after the binary point, so the
  // quotient never sits on a rounding tie.
  function automatic logic [31:0] code_recip(logic [5:0] n);
    logic [2:0]  l;
    logic [35:0] sh;
    logic [23:0] mant;
    logic [31:0] r;
    l = 3'd0;
    for (int i = 0; i < 6; i++) begin
      if (n[i]) l = 3'(i);
    end
    sh = {6{n}} << (3'd5 - l);
    mant = sh[35:12] + 24'(sh[11]);
    if (n == 6'd0) begin
      r = 32'd0;
    end else if (n == 6'd63) begin
      r = 32'h3F80_0000;
    end else begin
      r = {1'b0, 8'd121 + 8'(l), mant[22:0]};
    end
    return r;
  endfunction

  function automatic logic [31:0] nibble_to_single(logic [3:0] q);
    logic [1:0]  l;
    logic [26:0] t;
    logic [31:0] r;
    l = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (q[i]) l = 2'(i);
    end
    t = {q, 23'd0} >> l;
    r = (q == 4'd0) ? 32'd0 : {1'b0, 8'd127 + 8'(l), t[22:0]};
    return r;
  endfunction

endpackage

/* rtl/core/q4kbd_job_fifo.sv */
// Two-entry queue of dequantization jobs between the front and back parts.
// Depends on q4kbd_pkg for the job type.
module q4kbd_job_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  q4kbd_pkg::job_t wdata,
  input  logic            rd,
  output logic            full,
  output logic            empty,
  output q4kbd_pkg::job_t head
);
  import q4kbd_pkg::*;

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule

/* rtl/core/q4kbd_fp_mul.sv */
// Two-stage IEEE single-precision multiplier, round to nearest even.
// Depends on q4kbd_pkg for NaN constants.
module q4kbd_fp_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import q4kbd_pkg::*;

  logic               sa, sb, sgn;
  logic [7:0]         ea, eb;
  logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic               spec;
  logic [31:0]        spec_val;
  logic [47:0]        prod;
  logic signed [9:0]  esum;
  logic               stage_valid;
  logic               r_spec;
  logic [31:0]        r_spec_val;
  logic [47:0]        r_prod;
  logic signed [9:0]  r_esum;
  logic               r_sgn;
  logic [23:0]        mant;
  logic               g, st, up;
  logic [24:0]        rnd;
  logic signed [9:0]  e;
  logic [31:0]        res;

  always_comb begin
    sa = a[31];
    sb = b[31];
    ea = a[30:23];
    eb = b[30:23];
    sgn = sa ^ sb;
    nan_a = (ea == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (eb == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (ea == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (eb == 8'hFF) && (b[22:0] == 23'd0);
    zero_a = (ea == 8'd0);
    zero_b = (eb == 8'd0);
    spec = 1'b1;
    if (nan_a) begin
      spec_val = a | FP_QUIET_BIT;
    end else if (nan_b) begin
      spec_val = b | FP_QUIET_BIT;
    end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
      spec_val = FP_DEFAULT_NAN;
    end else if (inf_a || inf_b) begin
      spec_val = {sgn, 8'hFF, 23'd0};
    end else if (zero_a || zero_b) begin
      spec_val = {sgn, 31'd0};
    end else begin
      spec = 1'b0;
      spec_val = 32'd0;
    end
    prod = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    esum = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd127;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      r_spec     <= spec;
      r_spec_val <= spec_val;
      r_prod     <= prod;
      r_esum     <= esum;
      r_sgn      <= sgn;
    end
    if (stage_valid) y <= res;
  end

  always_comb begin
    if (r_prod[47]) begin
      mant = r_prod[47:24];
      g = r_prod[23];
      st = |r_prod[22:0];
      e = r_esum + 10'sd1;
    end else begin
      mant = r_prod[46:23];
      g = r_prod[22];
      st = |r_prod[21:0];
      e = r_esum;
    end
    up = g & (st | mant[0]);
    rnd = {1'b0, mant} + 25'(up);
    if (rnd[24]) e = e + 10'sd1;
    if (r_spec) begin
      res = r_spec_val;
    end else if (e >= 10'sd255) begin
      res = {r_sgn, 8'hFF, 23'd0};
    end else if (e <= 10'sd0) begin
      res = {r_sgn, 31'd0};
    end else begin
      res = {r_sgn, e[7:0], rnd[22:0]};
    end
  end

endmodule

/* rtl/core/q4kbd_fp_sub.sv */
// Two-stage IEEE single-precision subtractor y = a - b, round to nearest even.
// Depends on q4kbd_pkg for NaN constants.
module q4kbd_fp_sub (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import q4kbd_pkg::*;

  logic               sbn;
  logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic               spec;
  logic [31:0]        spec_val;
  logic               a_big;
  logic               sx, sy;
  logic [7:0]         ex, ey, diff;
  logic [26:0]        xm, ym, ys, mask;
  logic [27:0]        sum;
  logic               stage_valid;
  logic               r_spec;
  logic [31:0]        r_spec_val;
  logic [27:0]        r_sum;
  logic [7:0]         r_ex;
  logic               r_sx;
  logic [4:0]         lz;
  logic [26:0]        t;
  logic [23:0]        mant;
  logic               g, st, up;
  logic [24:0]        rnd;
  logic signed [9:0]  e;
  logic [31:0]        res;

  always_comb begin
    sbn = ~b[31];
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    zero_a = (a[30:23] == 8'd0);
    zero_b = (b[30:23] == 8'd0);
    spec = 1'b1;
    if (nan_a) begin
      spec_val = a | FP_QUIET_BIT;
    end else if (nan_b) begin
      spec_val = b | FP_QUIET_BIT;
    end else if (inf_a && inf_b) begin
      spec_val = (a[31] == b[31]) ? FP_DEFAULT_NAN : a;
    end else if (inf_a) begin
      spec_val = a;
    end else if (inf_b) begin
      spec_val = {sbn, b[30:0]};
    end else if (zero_a && zero_b) begin
      spec_val = {a[31] & sbn, 31'd0};
    end else if (zero_a) begin
      spec_val = {sbn, b[30:0]};
    end else if (zero_b) begin
      spec_val = a;
    end else begin
      spec = 1'b0;
      spec_val = 32'd0;
    end
    a_big = (a[30:0] >= b[30:0]);
    sx = a_big ? a[31] : sbn;
    sy = a_big ? sbn : a[31];
    ex = a_big ? a[30:23] : b[30:23];
    ey = a_big ? b[30:23] : a[30:23];
    xm = a_big ? {1'b1, a[22:0], 3'd0} : {1'b1, b[22:0], 3'd0};
    ym = a_big ? {1'b1, b[22:0], 3'd0} : {1'b1, a[22:0], 3'd0};
    diff = ex - ey;
    mask = ~({27{1'b1}} << diff);
    if (diff >= 8'd27) begin
      ys = 27'd1;
    end else begin
      ys = (ym >> diff) | 27'(|(ym & mask));
    end
    sum = (sx != sy) ? ({1'b0, xm} - {1'b0, ys}) : ({1'b0, xm} + {1'b0, ys});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      r_spec     <= spec;
      r_spec_val <= spec_val;
      r_sum      <= sum;
      r_ex       <= ex;
      r_sx       <= sx;
    end
    if (stage_valid) y <= res;
  end

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (r_sum[i]) lz = 5'(26 - i);
    end
    t = r_sum[26:0] << lz;
    if (r_sum[27]) begin
      mant = r_sum[27:4];
      g = r_sum[3];
      st = |r_sum[2:0];
      e = $signed({2'b00, r_ex}) + 10'sd1;
    end else begin
      mant = t[26:3];
      g = t[2];
      st = |t[1:0];
      e = $signed({2'b00, r_ex}) - $signed({5'd0, lz});
    end
    up = g & (st | mant[0]);
    rnd = {1'b0, mant} + 25'(up);
    if (rnd[24]) e = e + 10'sd1;
    if (r_spec) begin
      res = r_spec_val;
    end else if (r_sum == 28'd0) begin
      res = 32'd0;
    end else if (e >= 10'sd255) begin
      res = {r_sx, 8'hFF, 23'd0};
    end else if (e <= 10'sd0) begin
      res = {r_sx, 31'd0};
    end else begin
      res = {r_sx, e[7:0], rnd[22:0]};
    end
  end

endmodule

/* rtl/core/q4kbd_front.sv */
// Front part: takes block words, tracks block position and row count, keeps the
// header and code bytes, queues one job per in-row data word. Depends on q4kbd_pkg.
module q4kbd_front #(
  parameter int unsigned SUBBLOCK_SIZE = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  q4kbd_pkg::in_t                 item,
  output logic                           full,
  input  logic                           cfg_write,
  input  logic [q4kbd_pkg::ROW_W-1:0]    cfg_data,
  input  logic                           job_full,
  output logic                           job_push,
  output q4kbd_pkg::job_t                job
);
  import q4kbd_pkg::*;

  localparam int unsigned BLOCK_WORDS = SUBBLOCK_SIZE + 4;
  localparam int unsigned WP_W = $clog2(BLOCK_WORDS);
  localparam logic [OFS_W-1:0] SIZE_C = OFS_W'(SUBBLOCK_SIZE);

  logic [ROW_W-1:0] row_length;
  logic [WP_W-1:0]  wp, wp_next, wp_e;
  logic [ROW_W-1:0] ed, ed_next, ed_e, left;
  logic [15:0]      scale_half, min_half;
  logic [95:0]      codes;
  logic [OFS_W-1:0] ofs, ofs_next, ofs_step;
  logic [2:0]       sb, sb_next;
  logic [1:0]       code_idx;
  logic [3:0]       cnt;
  logic             acc, active, is_data;

  assign full = job_full;
  assign acc = push & ~job_full;

  always_comb begin
    wp_e = item.start_of_row ? '0 : wp;
    ed_e = item.start_of_row ? '0 : ed;
    active = (ed_e < row_length);
    is_data = (wp_e >= WP_W'(4));
    code_idx = wp_e[1:0] - 2'd1;
    left = row_length - ed_e;
    cnt = (left >= ROW_W'(8)) ? 4'd8 : left[3:0];
    ofs_step = ofs + OFS_W'(8);
    wp_next = wp_e;
    ed_next = ed_e;
    ofs_next = ofs;
    sb_next = sb;
    if (active) begin
      wp_next = (wp_e == WP_W'(BLOCK_WORDS - 1)) ? '0 : wp_e + WP_W'(1);
      if (wp_e == '0) begin
        ofs_next = '0;
        sb_next = 3'd0;
      end else if (is_data) begin
        ed_next = ed_e + ROW_W'(cnt);
        if (ofs_step >= SIZE_C) begin
          ofs_next = ofs_step - SIZE_C;
          sb_next = sb + 3'd1;
        end else begin
          ofs_next = ofs_step;
        end
      end
    end
    job.word = item.block_word;
    job.d = half_to_single(scale_half);
    job.dmin = half_to_single(min_half);
    job.codes = codes;
    job.index = ed_e;
    job.count = cnt;
    job.eor = (ed_e + ROW_W'(cnt)) >= row_length;
    job.sb = sb;
    job.ofs = ofs;
    job_push = acc & active & is_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RESET;
      wp         <= '0;
      ed         <= '0;
      scale_half <= 16'd0;
      min_half   <= 16'd0;
      ofs        <= '0;
      sb         <= 3'd0;
    end else begin
      if (cfg_write) row_length <= cfg_data;
      if (acc) begin
        wp  <= wp_next;
        ed  <= ed_next;
        ofs <= ofs_next;
        sb  <= sb_next;
        if (active && wp_e == '0) begin
          scale_half <= item.block_word[15:0];
          min_half   <= item.block_word[31:16];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && active && !is_data && wp_e != '0) begin
      codes[{code_idx, 5'd0} +: 32] <= item.block_word;
    end
  end

endmodule

/* rtl/core/q4kbd_back.sv */
// Back part: works through one queued job element by element on a shared
// multiplier and a subtractor, and holds the result word. Depends on q4kbd_pkg.
module q4kbd_back #(
  parameter int unsigned SUBBLOCK_SIZE = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_empty,
  input  q4kbd_pkg::job_t job,
  output logic            job_pop,
  output logic            empty,
  input  logic            pop,
  output q4kbd_pkg::out_t result
);
  import q4kbd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_W1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_W2   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_W3   = 4'd6;
  localparam logic [3:0] S_SUB  = 4'd7;
  localparam logic [3:0] S_WS   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;
  localparam logic [OFS_W-1:0] SIZE_C = OFS_W'(SUBBLOCK_SIZE);

  logic [3:0]       state, state_next;
  logic [2:0]       t;
  logic [2:0]       sb;
  logic [OFS_W-1:0] ofs;
  logic [31:0]      m1, mn;
  logic             ovalid;
  logic             mul_go, sub_go;
  logic [31:0]      mul_a, mul_b, mul_y, sub_y;
  logic [6:0]       sc_pos, mc_pos;
  logic [31:0]      qf;
  logic             last, load;

  q4kbd_fp_mul u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .a(mul_a), .b(mul_b), .y(mul_y)
  );

  q4kbd_fp_sub u_sub (
    .clk(clk), .rst(rst), .go(sub_go), .a(mul_y), .b(mn), .y(sub_y)
  );

  assign empty = ~ovalid;

  always_comb begin
    sc_pos = 7'(sb) * 7'd6;
    mc_pos = sc_pos + 7'd48;
    qf = nibble_to_single(job.word[{t, 2'b00} +: 4]);
    last = (4'(t) == job.count - 4'd1);
    load = (state == S_OUT) && (!ovalid || pop);
    job_pop = load && last;
    mul_go = (state == S_M1) || (state == S_M2) || (state == S_M3);
    sub_go = (state == S_SUB);
    unique case (state)
      S_M1: begin
        mul_a = job.d;
        mul_b = code_recip(job.codes[sc_pos +: 6]);
      end
      S_M2: begin
        mul_a = job.dmin;
        mul_b = code_recip(job.codes[mc_pos +: 6]);
      end
      default: begin
        mul_a = m1;
        mul_b = qf;
      end
    endcase
    state_next = state;
    unique case (state)
      S_IDLE: if (!job_empty) state_next = S_M1;
      S_M1:   state_next = S_W1;
      S_W1:   state_next = S_M2;
      S_M2:   state_next = S_W2;
      S_W2:   state_next = S_M3;
      S_M3:   state_next = S_W3;
      S_W3:   state_next = S_SUB;
      S_SUB:  state_next = S_WS;
      S_WS:   state_next = S_OUT;
      S_OUT:  if (load) state_next = last ? S_IDLE : S_M1;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      t   <= 3'd0;
      sb  <= job.sb;
      ofs <= job.ofs;
    end
    if (state == S_M2) m1 <= mul_y;
    if (state == S_M3) mn <= mul_y;
    if (load) begin
      result.value         <= sub_y;
      result.element_index <= job.index + ROW_W'(t);
      result.end_of_row    <= job.eor & last;
      result.last_of_item  <= last;
      t <= t + 3'd1;
      if (ofs + OFS_W'(1) == SIZE_C) begin
        ofs <= '0;
        sb  <= sb + 3'd1;
      end else begin
        ofs <= ofs + OFS_W'(1);
      end
    end
  end

endmodule

/* rtl/core/q4k_block_dequantizer_unit.sv */
// Top level of the Q4_K block dequantizer: front part, job queue, back part.
// Depends on q4kbd_pkg, q4kbd_front, q4kbd_job_fifo and q4kbd_back.
//
// Header and code words queue no job. A data word yields up to eight fp32 results,
// which the back part computes one after another (two scale products, the nibble
// product and the final subtraction go through one two-stage multiplier and a
// two-stage subtractor). After the last result of a job the back part passes
// through its idle state before it takes the next job. The front keeps
// accepting words while the two-entry job queue has room, and a finished result
// waits in the output register while the next one is computed.
module q4k_block_dequantizer_unit #(
  parameter int unsigned SUBBLOCK_SIZE = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  q4kbd_pkg::in_t              item,
  output logic                        full,
  input  logic                        cfg_write,
  input  logic [q4kbd_pkg::ROW_W-1:0] cfg_data,
  output logic                        empty,
  input  logic                        pop,
  output q4kbd_pkg::out_t             result
);
  import q4kbd_pkg::*;

  job_t job_in, job_head;
  logic job_push, job_pop, job_full, job_empty;

  q4kbd_front #(.SUBBLOCK_SIZE(SUBBLOCK_SIZE)) u_front (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .job_full(job_full), .job_push(job_push), .job(job_in)
  );

  q4kbd_job_fifo u_fifo (
    .clk(clk), .rst(rst), .wr(job_push), .wdata(job_in), .rd(job_pop),
    .full(job_full), .empty(job_empty), .head(job_head)
  );

  q4kbd_back #(.SUBBLOCK_SIZE(SUBBLOCK_SIZE)) u_back (
    .clk(clk), .rst(rst), .job_empty(job_empty), .job(job_head),
    .job_pop(job_pop), .empty(empty), .pop(pop), .result(result)
  );

endmodule
